### design/swfn_pkg.sv
// Shared types and constants for the sliding window feature normalizer.
`timescale 1ns / 1ps
`default_nettype none
package swfn_pkg;

  localparam int QUOT_BITS   = 35;
  localparam int ROOT_BITS   = 18;
  localparam int SCALE_SHIFT = 24;
  localparam int MEAN_SHIFT  = 4;

  localparam logic [1:0] CFG_VARIANCE_MODE = 2'd0;
  localparam logic [1:0] CFG_DIMS_IN_USE   = 2'd1;
  localparam logic [1:0] CFG_WINDOW_FRAMES = 2'd2;

  localparam logic       RESET_MODE   = 1'b1;
  localparam logic [6:0] RESET_DIMS   = 7'd40;
  localparam logic [8:0] RESET_WINDOW = 9'd256;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPDATE, ST_PRODUCT, ST_PREP, ST_LAUNCH, ST_SOLVE, ST_FINISH
  } ctl_state_t;

  typedef enum logic [1:0] {
    DU_IDLE, DU_DIV, DU_ROOT, DU_DONE
  } unit_state_t;

  typedef struct packed {
    logic start;
    logic sqrt_en;
  } unit_cmd_t;

endpackage
`default_nettype wire

### design/swfn_store.sv
// Window sample memory and per-dimension statistics memory with valid bits.
`timescale 1ns / 1ps
`default_nettype none
module swfn_store #(
  parameter int DIM_MAX = 64,
  parameter int DIM_W   = 6,
  parameter int ROW_W   = 8,
  parameter int SUM_W   = 24,
  parameter int SQ_W    = 39
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     clear,
  input  wire logic                     rd_en,
  input  wire logic [ROW_W-1:0]         rd_row,
  input  wire logic [DIM_W-1:0]         rd_dim,
  input  wire logic                     wr_en,
  input  wire logic signed [15:0]       wr_sample,
  input  wire logic signed [SUM_W-1:0]  wr_sum,
  input  wire logic [SQ_W-1:0]          wr_sq,
  output logic signed [15:0]            old_sample,
  output logic signed [SUM_W-1:0]       stat_sum,
  output logic [SQ_W-1:0]               stat_sq
);

  localparam int ADDR_W = ROW_W + DIM_W;

  logic [15:0]           window_mem [0:(1<<ADDR_W)-1];
  logic [SUM_W+SQ_W-1:0] stat_mem   [0:DIM_MAX-1];
  logic [DIM_MAX-1:0]    stat_valid;
  logic [ADDR_W-1:0]     addr_q;
  logic [DIM_W-1:0]      dim_q;
  logic [15:0]           old_q;
  logic [SUM_W+SQ_W-1:0] stat_q;
  logic                  hit_q;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_q <= {rd_row, rd_dim};
      dim_q  <= rd_dim;
      old_q  <= window_mem[{rd_row, rd_dim}];
      stat_q <= stat_mem[rd_dim];
      hit_q  <= stat_valid[rd_dim];
    end
    if (wr_en) begin
      window_mem[addr_q] <= wr_sample;
      stat_mem[dim_q]    <= {wr_sum, wr_sq};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      stat_valid <= '0;
    end else if (wr_en) begin
      stat_valid[dim_q] <= 1'b1;
    end
  end

  assign old_sample = old_q;
  assign stat_sum   = hit_q ? stat_q[SUM_W+SQ_W-1:SQ_W] : '0;
  assign stat_sq    = hit_q ? stat_q[SQ_W-1:0] : '0;

endmodule
`default_nettype wire

### design/swfn_solver.sv
// Iterative restoring divider, optionally followed by a bit-serial integer square root.
`timescale 1ns / 1ps
`default_nettype none
module swfn_solver #(
  parameter int NUM_W = 74,
  parameter int DEN_W = 48
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire swfn_pkg::unit_cmd_t            cmd,
  input  wire logic [NUM_W-1:0]               num,
  input  wire logic [DEN_W-1:0]               den,
  output logic                                done,
  output logic [swfn_pkg::QUOT_BITS-1:0]      quotient
);

  localparam int QB    = swfn_pkg::QUOT_BITS;
  localparam int RB    = swfn_pkg::ROOT_BITS;
  localparam int CNT_W = $clog2(QB);

  swfn_pkg::unit_state_t state, state_next;

  logic [DEN_W-1:0]  rem;
  logic [QB-1:0]     low;
  logic [QB-1:0]     quo;
  logic [CNT_W-1:0]  cnt;
  logic [RB-1:0]     root;
  logic [RB-1:0]     probe;
  logic              sqrt_mode;

  logic [NUM_W-1:0]  num_hi;
  logic              ovf;
  logic [DEN_W:0]    trial;
  logic              ge;
  logic [DEN_W:0]    diff;
  logic [RB-1:0]     cand;
  logic [2*RB-1:0]   cand_sq;
  logic [RB:0]       root_inc;

  always_comb begin
    num_hi   = num >> QB;
    ovf      = num_hi >= NUM_W'(den);
    trial    = {rem, low[QB-1]};
    ge       = trial >= {1'b0, den};
    diff     = trial - {1'b0, den};
    cand     = root | probe;
    cand_sq  = cand * cand;
    root_inc = {1'b0, root} + 1'b1;
  end

  always_comb begin
    state_next = state;
    case (state)
      swfn_pkg::DU_IDLE: begin
        if (cmd.start) begin
          if (ovf) state_next = cmd.sqrt_en ? swfn_pkg::DU_ROOT : swfn_pkg::DU_DONE;
          else     state_next = swfn_pkg::DU_DIV;
        end
      end
      swfn_pkg::DU_DIV: begin
        if (cnt == '0) state_next = sqrt_mode ? swfn_pkg::DU_ROOT : swfn_pkg::DU_DONE;
      end
      swfn_pkg::DU_ROOT: begin
        if (probe[0]) state_next = swfn_pkg::DU_DONE;
      end
      swfn_pkg::DU_DONE: state_next = swfn_pkg::DU_IDLE;
      default: state_next = swfn_pkg::DU_IDLE;
    endcase
  end

  always_comb begin
    done     = (state == swfn_pkg::DU_DONE);
    quotient = sqrt_mode ? QB'(root_inc[RB:1]) : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swfn_pkg::DU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      swfn_pkg::DU_IDLE: begin
        if (cmd.start) begin
          sqrt_mode <= cmd.sqrt_en;
          rem       <= DEN_W'(num_hi);
          low       <= num[QB-1:0];
          quo       <= ovf ? '1 : '0;
          cnt       <= CNT_W'(QB - 1);
          root      <= '0;
          probe     <= RB'(1) << (RB - 1);
        end
      end
      swfn_pkg::DU_DIV: begin
        rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo <= {quo[QB-2:0], ge};
        low <= low << 1;
        cnt <= cnt - 1'b1;
      end
      swfn_pkg::DU_ROOT: begin
        if (cand_sq <= (2*RB)'(quo)) root <= cand;
        probe <= probe >> 1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### design/sliding_window_feature_normalizer_top.sv
// Top level of the sliding window feature normalizer.
// Coefficients enter on the in_valid/in_ready channel, frame after frame,
// dimension 0 first; each transaction yields one result transaction on
// out_valid/out_ready carrying normalized (Q4.11 in variance mode, Q12.3
// in mean-only mode), frame_last, saturated and variance_floored. Registers
// are written through cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and writes belong in idle periods. Writing
// dims_in_use or window_frames restarts the window statistics.
// One coefficient is processed at a time. A transaction runs through the
// shared solver unit: restoring division, one quotient bit each step,
// then, in variance mode only, a square root, one root bit each step.
// A zero variance skips the solver. The statistics live in a window memory
// and a per-dimension memory, read then written back once per coefficient.
// Reset restores the register defaults and empties the statistics at once
// through per-dimension valid bits; no clearing pass is needed. A result
// held by a stalled receiver waits in the output register, and the next
// coefficient is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_feature_normalizer_top #(
  parameter int DIM_MAX    = 64,
  parameter int WINDOW_MAX = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] coefficient,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      normalized,
  output logic                    frame_last,
  output logic                    saturated,
  output logic                    variance_floored,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [8:0]         cfg_data
);

  localparam int LOG_W  = $clog2(WINDOW_MAX);
  localparam int DIM_W  = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int DCNT_W = $clog2(DIM_MAX + 1);
  localparam int ROW_W  = LOG_W;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = 16 + LOG_W;
  localparam int SQ_W   = 31 + LOG_W;
  localparam int MAG_W  = SUM_W + 1;
  localparam int V_W    = SQ_W + CNT_W;
  localparam int NUM_W  = 2 * MAG_W + swfn_pkg::SCALE_SHIFT;
  localparam int QB     = swfn_pkg::QUOT_BITS;

  swfn_pkg::ctl_state_t state, state_next;
  swfn_pkg::unit_cmd_t  cmd;

  logic              variance_mode;
  logic [6:0]        dims_cfg;
  logic [8:0]        window_cfg;
  logic [CNT_W-1:0]  fill_count;
  logic [ROW_W-1:0]  oldest_row;
  logic [DIM_W-1:0]  coef_index;

  logic [DCNT_W-1:0] dims_eff;
  logic [CNT_W-1:0]  win_eff;
  logic              full;
  logic [DIM_W-1:0]  d_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [CNT_W-1:0]  n_cur;
  logic              last_cur;
  logic              in_fire;
  logic              cfg_fire;
  logic              geom_clear;
  logic              wr_en;

  logic signed [15:0]      x_q;
  logic                    full_q;
  logic [CNT_W-1:0]        n_q;
  logic                    last_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]         sq_q;
  logic [V_W-1:0]          nq_q;
  logic [V_W-1:0]          s2_q;
  logic signed [MAG_W:0]   d_q;
  logic [NUM_W-1:0]        num_q;
  logic [V_W-1:0]          den_q;
  logic                    sqrt_q;
  logic                    floored_q;
  logic                    neg_q;
  logic [QB-1:0]           q_res;

  logic signed [15:0]       old_sample;
  logic signed [SUM_W-1:0]  stat_sum;
  logic [SQ_W-1:0]          stat_sq;
  logic signed [15:0]       old_val;
  logic signed [31:0]       old_sq;
  logic signed [31:0]       x_sq;
  logic signed [SUM_W-1:0]  sum_new;
  logic [SQ_W-1:0]          sq_new;
  logic [V_W-1:0]           nq_val;
  logic [SUM_W-1:0]         s_abs;
  logic [2*SUM_W-1:0]       s2_val;
  logic signed [MAG_W:0]    nx_val;
  logic signed [MAG_W:0]    d_val;
  logic [V_W-1:0]           v_val;
  logic                     neg_val;
  logic [MAG_W:0]           mag_full;
  logic [MAG_W-1:0]         mag;
  logic [2*MAG_W-1:0]       mag_sq;
  logic                     solve_done;
  logic [QB-1:0]            quotient;
  logic                     sat_val;
  logic [16:0]              q_clip;
  logic [16:0]              res_val;
  logic                     out_load;

  swfn_store #(
    .DIM_MAX (DIM_MAX),
    .DIM_W   (DIM_W),
    .ROW_W   (ROW_W),
    .SUM_W   (SUM_W),
    .SQ_W    (SQ_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .clear      (geom_clear),
    .rd_en      (in_fire),
    .rd_row     (row_cur),
    .rd_dim     (d_cur),
    .wr_en      (wr_en),
    .wr_sample  (x_q),
    .wr_sum     (sum_new),
    .wr_sq      (sq_new),
    .old_sample (old_sample),
    .stat_sum   (stat_sum),
    .stat_sq    (stat_sq)
  );

  swfn_solver #(
    .NUM_W (NUM_W),
    .DEN_W (V_W)
  ) u_solver (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .num      (num_q),
    .den      (den_q),
    .done     (solve_done),
    .quotient (quotient)
  );

  always_comb begin
    if (dims_cfg == '0)                  dims_eff = DCNT_W'(1);
    else if (32'(dims_cfg) > DIM_MAX)    dims_eff = DCNT_W'(DIM_MAX);
    else                                 dims_eff = DCNT_W'(dims_cfg);
    if (window_cfg == '0)                win_eff = CNT_W'(1);
    else if (32'(window_cfg) > WINDOW_MAX) win_eff = CNT_W'(WINDOW_MAX);
    else                                 win_eff = CNT_W'(window_cfg);

    full     = fill_count >= win_eff;
    d_cur    = (DCNT_W'(coef_index) >= dims_eff) ? '0 : coef_index;
    row_cur  = full ? oldest_row : fill_count[ROW_W-1:0];
    n_cur    = full ? win_eff : fill_count + 1'b1;
    last_cur = (DCNT_W'(d_cur) == dims_eff - 1'b1);

    in_fire    = in_valid && in_ready;
    cfg_fire   = cfg_valid && cfg_ready;
    geom_clear = cfg_fire &&
                 (cfg_index == swfn_pkg::CFG_DIMS_IN_USE ||
                  cfg_index == swfn_pkg::CFG_WINDOW_FRAMES);
  end

  always_comb begin
    old_val = full_q ? old_sample : 16'sd0;
    old_sq  = old_val * old_val;
    x_sq    = x_q * x_q;
    sum_new = stat_sum - SUM_W'(old_val) + SUM_W'(x_q);
    sq_new  = stat_sq - SQ_W'($unsigned(old_sq)) + SQ_W'($unsigned(x_sq));

    nq_val  = n_q * sq_q;
    s_abs   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    s2_val  = s_abs * s_abs;
    nx_val  = $signed({1'b0, n_q}) * x_q;
    d_val   = nx_val - (MAG_W+1)'(sum_q);

    v_val    = (nq_q > s2_q) ? nq_q - s2_q : '0;
    neg_val  = d_q[MAG_W];
    mag_full = neg_val ? $unsigned(-d_q) : $unsigned(d_q);
    mag      = mag_full[MAG_W-1:0];
    mag_sq   = mag * mag;
  end

  always_comb begin
    if (neg_q) begin
      sat_val = q_res > QB'(32768);
      q_clip  = sat_val ? 17'd32768 : q_res[16:0];
      res_val = 17'd0 - q_clip;
    end else begin
      sat_val = q_res > QB'(32767);
      q_clip  = sat_val ? 17'd32767 : q_res[16:0];
      res_val = q_clip;
    end
    out_load = (state == swfn_pkg::ST_FINISH) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      swfn_pkg::ST_IDLE:    if (in_fire) state_next = swfn_pkg::ST_UPDATE;
      swfn_pkg::ST_UPDATE:  state_next = swfn_pkg::ST_PRODUCT;
      swfn_pkg::ST_PRODUCT: state_next = swfn_pkg::ST_PREP;
      swfn_pkg::ST_PREP: begin
        if (variance_mode && v_val == '0) state_next = swfn_pkg::ST_FINISH;
        else                              state_next = swfn_pkg::ST_LAUNCH;
      end
      swfn_pkg::ST_LAUNCH:  state_next = swfn_pkg::ST_SOLVE;
      swfn_pkg::ST_SOLVE:   if (solve_done) state_next = swfn_pkg::ST_FINISH;
      swfn_pkg::ST_FINISH:  if (out_load) state_next = swfn_pkg::ST_IDLE;
      default:              state_next = swfn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == swfn_pkg::ST_IDLE);
    wr_en       = (state == swfn_pkg::ST_UPDATE);
    cmd.start   = (state == swfn_pkg::ST_LAUNCH);
    cmd.sqrt_en = sqrt_q;
    cfg_ready   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swfn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      variance_mode <= swfn_pkg::RESET_MODE;
      dims_cfg      <= swfn_pkg::RESET_DIMS;
      window_cfg    <= swfn_pkg::RESET_WINDOW;
      fill_count    <= '0;
      oldest_row    <= '0;
      coef_index    <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        swfn_pkg::CFG_VARIANCE_MODE: variance_mode <= cfg_data[0];
        swfn_pkg::CFG_DIMS_IN_USE:   dims_cfg      <= cfg_data[6:0];
        swfn_pkg::CFG_WINDOW_FRAMES: window_cfg    <= cfg_data;
        default: begin
        end
      endcase
      if (geom_clear) begin
        fill_count <= '0;
        oldest_row <= '0;
        coef_index <= '0;
      end
    end else if (in_fire) begin
      if (last_cur) begin
        coef_index <= '0;
        if (!full) begin
          fill_count <= fill_count + 1'b1;
        end else if (CNT_W'(oldest_row) + 1'b1 >= win_eff) begin
          oldest_row <= '0;
        end else begin
          oldest_row <= oldest_row + 1'b1;
        end
      end else begin
        coef_index <= d_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_q    <= coefficient;
      full_q <= full;
      n_q    <= n_cur;
      last_q <= last_cur;
    end
    if (state == swfn_pkg::ST_UPDATE) begin
      sum_q <= sum_new;
      sq_q  <= sq_new;
    end
    if (state == swfn_pkg::ST_PRODUCT) begin
      nq_q <= nq_val;
      s2_q <= V_W'(s2_val);
      d_q  <= d_val;
    end
    if (state == swfn_pkg::ST_PREP) begin
      neg_q  <= neg_val;
      sqrt_q <= variance_mode;
      if (variance_mode) begin
        num_q     <= {mag_sq, {swfn_pkg::SCALE_SHIFT{1'b0}}};
        den_q     <= v_val;
        floored_q <= (v_val == '0);
        q_res     <= '0;
      end else begin
        num_q     <= NUM_W'({mag, {swfn_pkg::MEAN_SHIFT{1'b0}}}) + NUM_W'(n_q);
        den_q     <= V_W'({n_q, 1'b0});
        floored_q <= 1'b0;
      end
    end
    if (state == swfn_pkg::ST_SOLVE && solve_done) begin
      q_res <= quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      normalized       <= $signed(res_val[15:0]);
      frame_last       <= last_q;
      saturated        <= sat_val;
      variance_floored <= floored_q;
    end
  end

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the sliding window feature normalizer top level.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int DIMS_CAP   = 64;
  localparam int WIN_CAP    = 256;
  localparam int CYCLE_CAP  = 2000000;
  localparam int HOLD_LEN   = 400;
  localparam int NUM_PHASES = 6;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic signed [15:0] norm;
    logic               last;
    logic               sat;
    logic               flo;
  } norm_result_t;

  typedef struct {
    logic signed [15:0] coef;
    logic               typed;
    norm_result_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] coefficient = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] normalized;
  logic frame_last, saturated, variance_floored;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  logic hold_req = 1'b0;
  int hold_left = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  int fails = 0;
  int cycles = 0;
  logic signed [15:0] last_coef = '0;

  norm_result_t expected_q[$];

  // normalizer state mirror
  logic               nm_mode = swfn_pkg::RESET_MODE;
  logic [6:0]         nm_dims = swfn_pkg::RESET_DIMS;
  logic [8:0]         nm_win  = swfn_pkg::RESET_WINDOW;
  logic signed [15:0] frame_ring [DIMS_CAP*WIN_CAP];
  longint             dim_sum [DIMS_CAP];
  longint unsigned    dim_sq  [DIMS_CAP];
  int                 frames_held = 0;
  int                 oldest = 0;
  int                 coef_pos = 0;

  sliding_window_feature_normalizer_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .coefficient(coefficient),
    .out_valid(out_valid), .out_ready(out_ready), .normalized(normalized),
    .frame_last(frame_last), .saturated(saturated),
    .variance_floored(variance_floored),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_pct);
    end
  end

  always @(posedge clk) begin
    norm_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: normalized %0d", normalized);
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (normalized !== e.norm) begin
          $error("normalized: expected %0d, got %0d", e.norm, normalized);
          fails++;
        end
        if (frame_last !== e.last) begin
          $error("frame_last: expected %0d, got %0d", e.last, frame_last);
          fails++;
        end
        if (saturated !== e.sat) begin
          $error("saturated: expected %0d, got %0d", e.sat, saturated);
          fails++;
        end
        if (variance_floored !== e.flo) begin
          $error("variance_floored: expected %0d, got %0d", e.flo, variance_floored);
          fails++;
        end
      end
    end
  end

  function automatic bit root_fits(longint unsigned q, longint unsigned v,
                                   longint unsigned a);
    logic [127:0] t, lhs, rhs;
    if (q == 0) return 1'b1;
    t = 128'(2 * q - 1);
    lhs = t * t * 128'(v);
    rhs = 128'(2 * a) * 128'(2 * a);
    return lhs <= rhs;
  endfunction

  task automatic restart_stats();
    for (int i = 0; i < DIMS_CAP; i++) begin
      dim_sum[i] = 0;
      dim_sq[i] = 0;
    end
    frames_held = 0;
    oldest = 0;
    coef_pos = 0;
  endtask

  function automatic norm_result_t normalize_coef(logic signed [15:0] coef);
    norm_result_t r;
    int dims, win, d, row, idx;
    longint n, x, s, diff, old;
    longint unsigned mag, q, sabs, nq, v, a, lo, hi, mid;
    bit full, neg;
    dims = (nm_dims < 1) ? 1 : (nm_dims > DIMS_CAP) ? DIMS_CAP : int'(nm_dims);
    win = (nm_win < 1) ? 1 : (nm_win > WIN_CAP) ? WIN_CAP : int'(nm_win);
    d = (coef_pos >= dims) ? 0 : coef_pos;
    full = frames_held >= win;
    row = full ? oldest : frames_held;
    if (row >= win) row = 0;
    idx = row * DIMS_CAP + d;
    x = longint'(coef);
    if (full) begin
      old = longint'(frame_ring[idx]);
      dim_sum[d] -= old;
      dim_sq[d] -= longint'(old * old);
    end
    frame_ring[idx] = coef;
    dim_sum[d] += x;
    dim_sq[d] += longint'(x * x);
    n = full ? win : frames_held + 1;
    s = dim_sum[d];
    diff = n * x - s;
    neg = diff < 0;
    mag = neg ? -diff : diff;
    r.flo = 1'b0;
    r.sat = 1'b0;
    if (!nm_mode) begin
      q = (16 * mag + n) / (2 * n);
    end else begin
      sabs = (s < 0) ? -s : s;
      nq = n * dim_sq[d];
      v = (nq > sabs * sabs) ? nq - sabs * sabs : 0;
      if (v == 0) begin
        r.flo = 1'b1;
        q = 0;
      end else begin
        a = 2048 * mag;
        lo = 0;
        hi = 32769;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          if (root_fits(mid, v, a)) lo = mid;
          else hi = mid - 1;
        end
        q = lo;
      end
    end
    if (neg) begin
      if (q > 32768) begin
        q = 32768;
        r.sat = 1'b1;
      end
      r.norm = 16'(-longint'(q));
    end else begin
      if (q > 32767) begin
        q = 32767;
        r.sat = 1'b1;
      end
      r.norm = 16'(q);
    end
    r.last = (d == dims - 1);
    if (r.last) begin
      coef_pos = 0;
      if (!full) frames_held++;
      else oldest = (oldest + 1 >= win) ? 0 : oldest + 1;
    end else begin
      coef_pos = d + 1;
    end
    return r;
  endfunction

  task automatic idle_gap();
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_coef(logic signed [15:0] c, bit typed, norm_result_t want);
    norm_result_t r;
    idle_gap();
    in_valid <= 1'b1;
    coefficient <= c;
    do @(posedge clk); while (!in_ready);
    r = normalize_coef(c);
    expected_q.push_back(typed ? want : r);
    last_coef = c;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      swfn_pkg::CFG_VARIANCE_MODE: nm_mode = data[0];
      swfn_pkg::CFG_DIMS_IN_USE: begin
        nm_dims = data[6:0];
        restart_stats();
      end
      swfn_pkg::CFG_WINDOW_FRAMES: begin
        nm_win = data;
        restart_stats();
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] pick_coef();
    case ($urandom_range(7))
      0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1: return 16'($signed($urandom_range(31)) - 16);
      2: return last_coef;
      default: return 16'($urandom);
    endcase
  endfunction

  stim_row_t rows[$];
  norm_result_t none_r;

  int ph_mode  [NUM_PHASES] = '{0, 1, 1, 0, 1, 1};
  int ph_dims  [NUM_PHASES] = '{0, 3, 1, 64, 127, 5};
  int ph_win   [NUM_PHASES] = '{1, 4, 256, 2, 511, 3};
  int ph_items [NUM_PHASES] = '{60, 100, 300, 200, 60, 80};
  int tx_pcts  [4] = '{0, 56, 0, 34};
  int rx_pcts  [4] = '{0, 0, 56, 34};

  initial begin
    logic signed [15:0] seeds [20] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001,
      16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00, 16'sh7FFF,
      16'sh8000, 16'sh0100, 16'shFF01, 16'sh1234, 16'shEDCB, 16'sh4000,
      16'shC000, 16'sh0002, 16'shFFFE, 16'sh7FFE};
    stim_row_t row;
    for (int i = 0; i < 20; i++) begin
      row.coef = seeds[i];
      row.typed = 1'b1;
      row.want = '{norm: 16'sd0, last: 1'b0, sat: 1'b0, flo: 1'b1};
      rows.push_back(row);
    end
    for (int i = 0; i < 5; i++) begin
      row.coef = 16'($urandom);
      row.typed = 1'b0;
      rows.push_back(row);
    end
    none_r = '{norm: 16'sd0, last: 1'b0, sat: 1'b0, flo: 1'b0};
    restart_stats();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_coef(rows[i].coef, rows[i].typed, rows[i].want);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_pct = 0;
      rx_pct = 0;
      write_reg(swfn_pkg::CFG_VARIANCE_MODE, 9'(ph_mode[p]));
      write_reg(swfn_pkg::CFG_DIMS_IN_USE, 9'(ph_dims[p]));
      write_reg(swfn_pkg::CFG_WINDOW_FRAMES, 9'(ph_win[p]));
      if (p == NUM_PHASES - 1) write_reg(CFG_UNUSED, 9'($urandom));
      tx_pct = tx_pcts[p % 4];
      rx_pct = rx_pcts[p % 4];
      for (int k = 0; k < ph_items[p]; k++) begin
        if (p == 1 && k == 20) begin
          hold_req <= 1'b1;
          send_coef(pick_coef(), 1'b0, none_r);
          hold_req <= 1'b0;
        end else begin
          if (p == 2 && k == 150) drain();
          send_coef(pick_coef(), 1'b0, none_r);
        end
      end
      drain();
    end

    tx_pct = 0;
    rx_pct = 0;
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
